/* rtl/multiset_bag_table_top_macros.svh */
//------------------------------------------------------------------------------
// Multiset bag table assertion macros
// Shorthand for clocked implication checks used at the end of the top level.
//------------------------------------------------------------------------------
`ifndef MULTISET_BAG_TABLE_TOP_MACROS_SVH
`define MULTISET_BAG_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define MBT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MBT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/mbt_pkg.sv */
//------------------------------------------------------------------------------
// Multiset bag table package
// Action codes, field widths and the transaction token passed along the cells.
//------------------------------------------------------------------------------
package mbt_pkg;

   localparam int FIELD_W = 6;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_ERASE  = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   typedef struct packed {
      logic               valid;
      logic [1:0]         action;
      logic               found;
      logic [FIELD_W-1:0] copies;
   } tok_type;

endpackage

/* rtl/multiset_bag_table_top.sv */
//------------------------------------------------------------------------------
// Multiset bag table top level
// Fixed-capacity bag of values kept compacted in slot order, one cell a slot.
//------------------------------------------------------------------------------
// An accepted transaction walks the row of CAPACITY_ENTRIES cells, one cell per
// cycle unless the row is held; each cell compares, counts, writes or shifts its
// own slot as the token passes. The result is registered when the token leaves
// the last cell, and the request side is ready again in the same cycle that the
// result is presented. One transaction is in the row at a time. A waiting result
// does not block the next acceptance; that transaction walks the row and holds
// in the last cell, with the request side not ready, until the earlier result is
// taken. An insert into a full bag is refused with full_refused set and the
// contents unchanged.
module multiset_bag_table_top #(
   parameter int CAPACITY_ENTRIES = 32,
   parameter int VALUE_BITS       = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_item_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [5:0]  rsp_copies,
   output logic [5:0]  rsp_fill_count,
   output logic        rsp_full_refused
);

   localparam int CNT_W = $clog2(CAPACITY_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY_ENTRIES);

   mbt_pkg::tok_type      tok_chain   [CAPACITY_ENTRIES+1];
   logic [VALUE_BITS-1:0] value_chain [CAPACITY_ENTRIES+1];
   logic [VALUE_BITS-1:0] entry       [CAPACITY_ENTRIES];
   logic [CAPACITY_ENTRIES-1:0] tok_valids;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             found_ff, found_in;
   logic [5:0]       copies_ff, copies_in;
   logic [5:0]       fill_ff, fill_in;
   logic             refused_ff, refused_in;

   logic             advance;
   logic             accept;
   logic             rsp_load;
   logic             refused;
   logic             erase_hit;
   mbt_pkg::tok_type tok_last;

   assign tok_last  = tok_chain[CAPACITY_ENTRIES];
   assign advance   = !tok_last.valid || !rsp_valid_ff || rsp_ready;
   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_load  = advance && tok_last.valid;

   assign tok_chain[0].valid  = accept;
   assign tok_chain[0].action = req_action;
   assign tok_chain[0].found  = 1'b0;
   assign tok_chain[0].copies = '0;
   assign value_chain[0]      = VALUE_BITS'(req_item_value);

   for (genvar i = 0; i < CAPACITY_ENTRIES; i++) begin : g_cell
      logic [VALUE_BITS-1:0] next_entry;
      if (i == CAPACITY_ENTRIES - 1) begin : g_tail
         assign next_entry = entry[i];
      end else begin : g_body
         assign next_entry = entry[i+1];
      end
      mbt_cell #(
         .VALUE_BITS (VALUE_BITS),
         .CNT_W      (CNT_W),
         .IDX        (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .count_i      (count_ff),
         .tok_i        (tok_chain[i]),
         .value_i      (value_chain[i]),
         .next_entry_i (next_entry),
         .tok_o        (tok_chain[i+1]),
         .value_o      (value_chain[i+1]),
         .entry_o      (entry[i])
      );
      assign tok_valids[i] = tok_chain[i+1].valid;
   end

   assign refused = (tok_last.action == mbt_pkg::ACT_INSERT) && (count_ff == CAP);
   assign erase_hit = rsp_load && (tok_last.action == mbt_pkg::ACT_ERASE) && tok_last.found;

   always_comb begin
      count_in     = count_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      copies_in    = copies_ff;
      fill_in      = fill_ff;
      refused_in   = refused_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      if (rsp_load) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         case (tok_last.action)
            mbt_pkg::ACT_INSERT: begin
               if (!refused) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            mbt_pkg::ACT_ERASE: begin
               if (tok_last.found) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            mbt_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
         found_in   = ((tok_last.action == mbt_pkg::ACT_LOOKUP) ||
                       (tok_last.action == mbt_pkg::ACT_ERASE)) ? tok_last.found : 1'b0;
         copies_in  = (tok_last.action == mbt_pkg::ACT_LOOKUP) ? tok_last.copies : 6'd0;
         fill_in    = 6'(count_in);
         refused_in = refused;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff   <= found_in;
      copies_ff  <= copies_in;
      fill_ff    <= fill_in;
      refused_ff <= refused_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_copies       = copies_ff;
   assign rsp_fill_count   = fill_ff;
   assign rsp_full_refused = refused_ff;

`include "multiset_bag_table_top_macros.svh"

   `MBT_ASSERT_IMP(a_count_cap, 1'b1, count_ff <= CAP, "fill count above capacity")
   `MBT_ASSERT_IMP(a_one_token, 1'b1, $countones(tok_valids) <= 1, "two transactions in row")
   `MBT_ASSERT_IMP(a_busy_token, tok_valids != '0, busy_ff, "token in row while not busy")
   `MBT_ASSERT_NXT(a_erase_dec, erase_hit, count_ff == $past(count_ff) - CNT_W'(1), "no shrink")

endmodule

/* rtl/mbt_cell.sv */
//------------------------------------------------------------------------------
// Multiset bag table cell
// Holds one slot. Applies the passing transaction to its slot and hands the
// token on to the next cell.
//------------------------------------------------------------------------------
module mbt_cell #(
   parameter int VALUE_BITS = 32,
   parameter int CNT_W      = 6,
   parameter int IDX        = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [CNT_W-1:0]      count_i,
   input  mbt_pkg::tok_type      tok_i,
   input  logic [VALUE_BITS-1:0] value_i,
   input  logic [VALUE_BITS-1:0] next_entry_i,
   output mbt_pkg::tok_type      tok_o,
   output logic [VALUE_BITS-1:0] value_o,
   output logic [VALUE_BITS-1:0] entry_o
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic [VALUE_BITS-1:0] entry_ff, entry_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   mbt_pkg::tok_type      tok_ff, tok_in;
   logic                  live;
   logic                  match;

   assign live  = MY_IDX < count_i;
   assign match = live && (entry_ff == value_i);

   always_comb begin
      tok_in   = tok_ff;
      value_in = value_ff;
      entry_in = entry_ff;
      if (advance) begin
         tok_in   = tok_i;
         value_in = value_i;
         if (tok_i.valid) begin
            case (tok_i.action)
               mbt_pkg::ACT_INSERT: begin
                  if (MY_IDX == count_i) begin
                     entry_in = value_i;
                  end
               end
               mbt_pkg::ACT_LOOKUP: begin
                  if (match) begin
                     tok_in.found  = 1'b1;
                     tok_in.copies = tok_i.copies + mbt_pkg::FIELD_W'(1);
                  end
               end
               mbt_pkg::ACT_ERASE: begin
                  if (tok_i.found || match) begin
                     tok_in.found = 1'b1;
                     entry_in     = next_entry_i;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.action <= tok_in.action;
      tok_ff.found  <= tok_in.found;
      tok_ff.copies <= tok_in.copies;
      value_ff      <= value_in;
      entry_ff      <= entry_in;
   end

   assign tok_o   = tok_ff;
   assign value_o = value_ff;
   assign entry_o = entry_ff;

endmodule
